### hdl/ipm_pkg.sv
// Shared types and constants for the ground plane projector.
// No dependencies; every other file but ipm_div imports this package.
`timescale 1ns / 1ps

package ipm_pkg;

  localparam int COEF_W = 20;
  localparam int PIX_W  = 12;
  localparam int CFG_W  = 60;
  localparam int IDX_W  = 3;
  localparam int PROD_W = 33;
  localparam int B_W    = 34;
  localparam int MAG_W  = 33;
  localparam int SQ_W   = 66;
  localparam int SUM_W  = 68;
  localparam int CMP_W  = 80;
  localparam int TP_W   = 54;
  localparam int NUM_W  = 53;

  localparam logic [CMP_W-1:0] HIT_SCALE = CMP_W'(10000);

  localparam logic [IDX_W-1:0] REG_ROW0  = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_ROW1  = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_ROW2  = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_TRANS = IDX_W'(3);

  typedef struct packed {
    logic [PIX_W-1:0] pixel_col;
    logic [PIX_W-1:0] pixel_row;
  } pixel_t;

  typedef struct packed {
    logic               point_valid;
    logic signed [15:0] map_col;
    logic signed [15:0] map_row;
  } point_t;

  typedef struct packed {
    logic             hit;
    logic             neg_x;
    logic             neg_y;
    logic [NUM_W-1:0] num_x;
    logic [NUM_W-1:0] num_y;
    logic [MAG_W-1:0] den;
  } ray_t;

  typedef struct packed {
    logic hit;
    logic neg_x;
    logic neg_y;
  } side_t;

  function automatic logic signed [COEF_W-1:0] field(input logic [CFG_W-1:0] word,
                                                     input int unsigned k);
    return word[COEF_W*k +: COEF_W];
  endfunction

endpackage

### hdl/ipm_div.sv
// Pipelined restoring divider, one quotient bit per stage, unsigned.
// Uses no package items; instantiated twice by the top level.
`timescale 1ns / 1ps

module ipm_div #(
  parameter int N_W    = 8,
  parameter int D_W    = 8,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [N_W-1:0]    num,
  input  logic [D_W-1:0]    den,
  input  logic [SIDE_W-1:0] side,
  output logic              out_valid,
  output logic [N_W-1:0]    quo,
  output logic [SIDE_W-1:0] out_side
);

  logic              vld [N_W];
  logic [D_W-1:0]    rem [N_W];
  logic [N_W-1:0]    nq  [N_W];
  logic [D_W-1:0]    dv  [N_W];
  logic [SIDE_W-1:0] sd  [N_W];

  for (genvar k = 0; k < N_W; k++) begin : g_stage
    logic              v_in;
    logic [D_W-1:0]    r_in;
    logic [N_W-1:0]    q_in;
    logic [D_W-1:0]    d_in;
    logic [SIDE_W-1:0] s_in;
    logic [D_W:0]      part;
    logic              ge;

    if (k == 0) begin : g_first
      assign v_in = in_valid;
      assign r_in = '0;
      assign q_in = num;
      assign d_in = den;
      assign s_in = side;
    end else begin : g_next
      assign v_in = vld[k-1];
      assign r_in = rem[k-1];
      assign q_in = nq[k-1];
      assign d_in = dv[k-1];
      assign s_in = sd[k-1];
    end

    assign part = {r_in, q_in[N_W-1]};
    assign ge   = part >= {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? D_W'(part - {1'b0, d_in}) : part[D_W-1:0];
        nq[k]  <= {q_in[N_W-2:0], ge};
        dv[k]  <= d_in;
        sd[k]  <= s_in;
      end
    end
  end

  assign out_valid = vld[N_W-1];
  assign quo       = nq[N_W-1];
  assign out_side  = sd[N_W-1];

endmodule

### hdl/ipm_ray.sv
// Ray formation and ground hit test: five pipeline stages.
// Depends on ipm_pkg; feeds the two ray dividers in the top level.
`timescale 1ns / 1ps

module ipm_ray (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  ipm_pkg::pixel_t              pix,
  input  logic [ipm_pkg::CFG_W-1:0]    row0,
  input  logic [ipm_pkg::CFG_W-1:0]    row1,
  input  logic [ipm_pkg::CFG_W-1:0]    row2,
  input  logic [ipm_pkg::CFG_W-1:0]    trans,
  output logic                         out_valid,
  output ipm_pkg::ray_t                ray
);
  import ipm_pkg::*;

  logic [CFG_W-1:0] rows [3];
  assign rows[0] = row0;
  assign rows[1] = row1;
  assign rows[2] = row2;

  logic v1, v2, v3, v4, v5;
  logic signed [PROD_W-1:0] pc [3];
  logic signed [PROD_W-1:0] pr [3];
  logic signed [B_W-1:0]    b  [3];
  logic [SQ_W-1:0]          sq [3];
  logic signed [TP_W-1:0]   tpx, tpy;
  logic                     bz_neg3, bz_neg4;
  logic [MAG_W-1:0]         bz_mag3, bz_mag4;
  logic [CMP_W-1:0]         lhs;
  logic [SUM_W-1:0]         rhs;
  logic [NUM_W-1:0]         nx4, ny4;
  logic                     negx4, negy4;
  logic [MAG_W-1:0]         bmag [3];
  logic signed [COEF_W-1:0] tz;

  assign tz = field(trans, 2);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      bmag[i] = b[i][B_W-1] ? MAG_W'(-b[i]) : MAG_W'(b[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pc[i] <= PROD_W'(field(rows[i], 0)) * PROD_W'($signed({1'b0, pix.pixel_col}));
        pr[i] <= PROD_W'(field(rows[i], 1)) * PROD_W'($signed({1'b0, pix.pixel_row}));
        b[i]  <= B_W'(pc[i]) + B_W'(pr[i]) + B_W'(field(rows[i], 2));
        sq[i] <= SQ_W'(bmag[i]) * SQ_W'(bmag[i]);
      end
      tpx     <= TP_W'(tz) * TP_W'(b[0]);
      tpy     <= TP_W'(tz) * TP_W'(b[1]);
      bz_neg3 <= b[2][B_W-1];
      bz_mag3 <= bmag[2];

      // The quotient sign is that of tz*b divided by a negative bz.
      lhs     <= CMP_W'(sq[2]) * HIT_SCALE;
      rhs     <= SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
      nx4     <= tpx[TP_W-1] ? NUM_W'(-tpx) : NUM_W'(tpx);
      ny4     <= tpy[TP_W-1] ? NUM_W'(-tpy) : NUM_W'(tpy);
      negx4   <= ~tpx[TP_W-1];
      negy4   <= ~tpy[TP_W-1];
      bz_neg4 <= bz_neg3;
      bz_mag4 <= bz_mag3;

      ray.hit   <= bz_neg4 && (lhs >= CMP_W'(rhs));
      ray.neg_x <= negx4;
      ray.neg_y <= negy4;
      ray.num_x <= nx4;
      ray.num_y <= ny4;
      ray.den   <= bz_mag4;
    end
  end

  assign out_valid = v5;

endmodule

### hdl/ipm_map.sv
// Ground point and top-down map coordinate stages, four pipeline stages.
// Depends on ipm_pkg.
`timescale 1ns / 1ps

module ipm_map #(
  parameter int MAP_SIZE         = 800,
  parameter int MAP_RANGE_METRES = 30
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  ipm_pkg::side_t              side,
  input  logic [ipm_pkg::NUM_W-1:0]   qx,
  input  logic [ipm_pkg::NUM_W-1:0]   qy,
  input  logic [ipm_pkg::CFG_W-1:0]   trans,
  output logic                        out_valid,
  output ipm_pkg::point_t             point
);
  import ipm_pkg::*;

  localparam longint SPAN  = longint'(MAP_RANGE_METRES) * 1024;
  localparam longint DEN   = 2 * SPAN;
  // Any distance past LIM maps to a value that saturates either way.
  localparam longint LIM   = (longint'(32768) * DEN + longint'(MAP_SIZE) - 1) /
                             longint'(MAP_SIZE);
  localparam int     X_W   = $clog2(LIM + 1);
  localparam int     SH    = $clog2(LIM * DEN);
  // Rounded-up reciprocal of DEN scaled by MAP_SIZE; exact for every x up to LIM.
  localparam longint RECIP = (longint'(MAP_SIZE) * (longint'(1) << SH) + DEN - 1) / DEN;
  localparam int     R_W   = $clog2(RECIP + 1);
  localparam int     P_W   = X_W + R_W;
  localparam int     Q_W   = P_W - SH;
  localparam int     G_W   = TP_W + 1;
  localparam int     DD_W  = G_W + 1;

  localparam logic signed [DD_W-1:0] SPAN_C  = DD_W'(SPAN);
  localparam logic signed [DD_W-1:0] LIM_POS = DD_W'(LIM);
  localparam logic signed [DD_W-1:0] LIM_NEG = -LIM_POS;
  localparam logic [X_W-1:0]         LIM_X   = X_W'(LIM);
  localparam logic [R_W-1:0]         RECIP_C = R_W'(RECIP);
  localparam logic [Q_W-1:0]         POS_MAX = Q_W'(32767);
  localparam logic [Q_W-1:0]         NEG_MAX = Q_W'(32768);

  logic v6, v7, v8;
  logic h6, h7, h8;
  logic signed [G_W-1:0]  gx, gy;
  logic signed [DD_W-1:0] dx, dy;
  logic [X_W-1:0]         ax7, ay7;
  logic                   sx7, sy7, sx8, sy8;
  logic [P_W-1:0]         prx8, pry8;

  function automatic logic [X_W-1:0] clamp_mag(input logic signed [DD_W-1:0] d);
    logic [X_W-1:0] m;
    if (d > LIM_POS || d < LIM_NEG) begin
      m = LIM_X;
    end else if (d[DD_W-1]) begin
      m = X_W'(-d);
    end else begin
      m = X_W'(d);
    end
    return m;
  endfunction

  always_comb begin
    dx = SPAN_C - DD_W'(gx);
    dy = SPAN_C - DD_W'(gy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
    end else if (en) begin
      v6 <= in_valid;
      v7 <= v6;
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h6   <= side.hit;
      gx   <= G_W'(field(trans, 0)) - (side.neg_x ? -G_W'(qx) : G_W'(qx));
      gy   <= G_W'(field(trans, 1)) - (side.neg_y ? -G_W'(qy) : G_W'(qy));
      h7   <= h6;
      sx7  <= dx[DD_W-1];
      sy7  <= dy[DD_W-1];
      ax7  <= clamp_mag(dx);
      ay7  <= clamp_mag(dy);
      h8   <= h7;
      sx8  <= sx7;
      sy8  <= sy7;
      prx8 <= P_W'(ax7) * P_W'(RECIP_C);
      pry8 <= P_W'(ay7) * P_W'(RECIP_C);
    end
  end

  function automatic logic signed [15:0] sat16(input logic neg, input logic [Q_W-1:0] q);
    logic signed [15:0] r;
    if (neg) begin
      r = (q >= NEG_MAX) ? 16'sh8000 : -16'(q);
    end else begin
      r = (q > POS_MAX) ? 16'sh7fff : 16'(q);
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      point.point_valid <= h8;
      point.map_col     <= h8 ? sat16(sy8, pry8[P_W-1:SH]) : '0;
      point.map_row     <= h8 ? sat16(sx8, prx8[P_W-1:SH]) : '0;
    end
  end

endmodule

### hdl/pixel_to_ground_plane_projector_core.sv
// Top level of the flat-ground pixel projector: config registers and pipeline.
// Depends on ipm_pkg, ipm_ray, ipm_div and ipm_map.
//
//   Port group   Role                     Handshake
//   pixel        camera pixel request     pixel_valid / pixel_stall
//   map_point    map point result         map_valid / map_stall
//   cfg          register write           cfg_valid / cfg_ready
//
// One pixel is taken every clock while pixel_stall is low; a result passes through the
// ray stages, the bit-per-stage ray dividers (most of the pipeline) and the map stages.
// rst is synchronous and clears all valid bits and the config registers.
// A stalled result freezes the whole pipeline, and pixel_stall rises with it.
`timescale 1ns / 1ps

module pixel_to_ground_plane_projector_core #(
  parameter int MAP_SIZE         = 800,
  parameter int MAP_RANGE_METRES = 30
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        pixel_valid,
  output logic                        pixel_stall,
  input  ipm_pkg::pixel_t             pixel,
  output logic                        map_valid,
  input  logic                        map_stall,
  output ipm_pkg::point_t             map_point,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ipm_pkg::IDX_W-1:0]   cfg_index,
  input  logic [ipm_pkg::CFG_W-1:0]   cfg_data
);
  import ipm_pkg::*;

  logic [CFG_W-1:0] row0, row1, row2, trans;
  logic             en;
  logic             ray_valid, dx_valid, dy_valid;
  ray_t             ray;
  logic [1:0]       dx_side;
  logic             dy_side;
  logic [NUM_W-1:0] qx, qy;
  side_t            side;

  assign cfg_ready   = 1'b1;
  assign en          = !(map_valid && map_stall);
  assign pixel_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      row0  <= '0;
      row1  <= '0;
      row2  <= '0;
      trans <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ROW0:  row0  <= cfg_data;
        REG_ROW1:  row1  <= cfg_data;
        REG_ROW2:  row2  <= cfg_data;
        REG_TRANS: trans <= cfg_data;
        default:   ;
      endcase
    end
  end

  ipm_ray u_ray (
    .clk, .rst, .en,
    .in_valid (pixel_valid),
    .pix      (pixel),
    .row0, .row1, .row2, .trans,
    .out_valid(ray_valid),
    .ray
  );

  ipm_div #(.N_W(NUM_W), .D_W(MAG_W), .SIDE_W(2)) u_div_x (
    .clk, .rst, .en,
    .in_valid (ray_valid),
    .num      (ray.num_x),
    .den      (ray.den),
    .side     ({ray.hit, ray.neg_x}),
    .out_valid(dx_valid),
    .quo      (qx),
    .out_side (dx_side)
  );

  ipm_div #(.N_W(NUM_W), .D_W(MAG_W), .SIDE_W(1)) u_div_y (
    .clk, .rst, .en,
    .in_valid (ray_valid),
    .num      (ray.num_y),
    .den      (ray.den),
    .side     (ray.neg_y),
    .out_valid(dy_valid),
    .quo      (qy),
    .out_side (dy_side)
  );

  assign side.hit   = dx_side[1];
  assign side.neg_x = dx_side[0];
  assign side.neg_y = dy_side;

  ipm_map #(.MAP_SIZE(MAP_SIZE), .MAP_RANGE_METRES(MAP_RANGE_METRES)) u_map (
    .clk, .rst, .en,
    .in_valid (dx_valid),
    .side,
    .qx, .qy, .trans,
    .out_valid(map_valid),
    .point    (map_point)
  );

  a_div_lockstep: assert property (@(posedge clk) disable iff (rst)
    dx_valid == dy_valid)
    else $error("ray dividers out of step");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    map_valid && !map_point.point_valid |-> map_point.map_col == 16'sd0
                                          && map_point.map_row == 16'sd0)
    else $error("rejected pixel carries a nonzero map point");

  a_stall_follows: assert property (@(posedge clk) disable iff (rst)
    pixel_stall == (map_valid && map_stall))
    else $error("input stall does not follow output backpressure");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !map_valid)
    else $error("result presented right after reset");

endmodule
